// ----- hdl/depth_columns_to_scan_core_assert.svh -----
// Assertion macros for the depth column scan core.
`ifndef DEPTH_COLUMNS_TO_SCAN_CORE_ASSERT_SVH
`define DEPTH_COLUMNS_TO_SCAN_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dcs_pkg.sv -----
package dcs_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = 8;
  localparam int ROW_W       = 10;
  localparam int ROW_END_W   = 11;
  localparam int FW_W        = 9;
  localparam int GAIN_W      = 16;
  localparam int AMP_W       = 12;
  localparam int SQ_W        = 32;
  localparam int RANGE_W     = 16;
  localparam int INTENS_W    = 20;
  localparam int SQRT_STEPS  = 16;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_START      = 2'd0;
  localparam logic [1:0] REG_ROW_END        = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
  localparam logic [1:0] REG_INTENSITY_GAIN = 2'd3;

  // result fields that ride along the square root pipeline
  typedef struct packed {
    logic [COL_W-1:0]    index;
    logic [INTENS_W-1:0] intensity;
    logic                found;
  } dcs_side_t;

endpackage

// ----- hdl/dcs_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module dcs_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [dcs_pkg::SQ_W-1:0]  in_value,
  input  dcs_pkg::dcs_side_t        in_side,
  output logic                      out_vld,
  output logic [dcs_pkg::RANGE_W-1:0] out_root,
  output dcs_pkg::dcs_side_t        out_side
);
  import dcs_pkg::*;

  logic [SQ_W-1:0] v_q    [SQRT_STEPS];
  logic [SQ_W-1:0] root_q [SQRT_STEPS];
  logic            vld_q  [SQRT_STEPS];
  dcs_side_t       side_q [SQRT_STEPS];

  logic [SQ_W-1:0] v_d    [SQRT_STEPS];
  logic [SQ_W-1:0] root_d [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] v_in;
    logic [SQ_W-1:0] root_in;
    logic [SQ_W:0]   trial;

    if (k == 0) begin : g_first
      assign v_in    = in_value;
      assign root_in = '0;
    end else begin : g_rest
      assign v_in    = v_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = {1'b0, root_in} + {1'b0, STEP_BIT};

    always_comb begin
      if ({1'b0, v_in} >= trial) begin
        v_d[k]    = v_in - trial[SQ_W-1:0];
        root_d[k] = (root_in >> 1) + STEP_BIT;
      end else begin
        v_d[k]    = v_in;
        root_d[k] = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= (k == 0) ? in_vld : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[k]    <= v_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= (k == 0) ? in_side : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_vld  = vld_q[SQRT_STEPS-1];
  assign out_root = root_q[SQRT_STEPS-1][RANGE_W-1:0];
  assign out_side = side_q[SQRT_STEPS-1];

endmodule

// ----- hdl/depth_columns_to_scan_core.sv -----
// Per-column nearest point scan from a raster ordered depth point stream.
// Pixel channel: pixel_valid / pixel_stall with row, column, x/y/z in mm and
// amplitude; a beat is taken on a clock edge with valid high and stall low.
// Scan channel: scan_valid / scan_stall with mirrored index, range in mm,
// gained intensity and found flag. Only beats on the last window row emit.
// Config: cfg_write / cfg_index / cfg_data, one register per write, while idle.
// Throughput: one pixel beat per clock while pixel_stall is low. A result
// passes 4 front stages, a 16 stage square root pipeline and the output
// register before it shows on scan_valid. The column store is one 256 x 44
// memory, read one stage ahead of the update, written by the update stage.
// Reset clears pipeline valids and loads the register defaults (window rows
// 0..119, 160 columns, unity gain). The column store is not cleared: each
// column is started on the first window row.
// Stall: while a held result is refused and another waits behind it, the
// whole pipeline freezes and pixel_stall goes high; otherwise beats flow.
module depth_columns_to_scan_core (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [dcs_pkg::GAIN_W-1:0]     cfg_data,
  // pixel channel
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [dcs_pkg::ROW_W-1:0]      pixel_row,
  input  logic [dcs_pkg::COL_W-1:0]      pixel_col,
  input  logic signed [15:0]             coord_x,
  input  logic signed [15:0]             coord_y,
  input  logic signed [15:0]             coord_z,
  input  logic [dcs_pkg::AMP_W-1:0]      amplitude,
  // scan channel
  output logic                           scan_valid,
  input  logic                           scan_stall,
  output logic [dcs_pkg::COL_W-1:0]      scan_index,
  output logic [dcs_pkg::RANGE_W-1:0]    scan_range,
  output logic [dcs_pkg::INTENS_W-1:0]   scan_intensity,
  output logic                           found
);
  import dcs_pkg::*;

  localparam int MEM_W = SQ_W + AMP_W;

  // ---------------------------------------------------------------- config
  logic [ROW_W-1:0]     row_start;
  logic [ROW_END_W-1:0] row_end;
  logic [FW_W-1:0]      frame_width;
  logic [GAIN_W-1:0]    intensity_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_start      <= '0;
      row_end        <= ROW_END_W'(120);
      frame_width    <= FW_W'(160);
      intensity_gain <= GAIN_W'(256);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_START:      row_start      <= cfg_data[ROW_W-1:0];
        REG_ROW_END:        row_end        <= cfg_data[ROW_END_W-1:0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[FW_W-1:0];
        REG_INTENSITY_GAIN: intensity_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  // One enable moves every stage. It drops only when the square root output
  // has a result and the output register is full and refused.
  logic      advance;
  logic      sq_vld;
  logic [RANGE_W-1:0] sq_root;
  dcs_side_t sq_side;

  assign advance     = !(scan_valid && scan_stall && sq_vld);
  assign pixel_stall = !advance;

  // --------------------------------------------- stage 0: window and abs
  logic [ROW_END_W-1:0] end_eff;
  logic                 in_win;
  logic                 in_col_ok;
  logic                 in_use;
  logic [15:0]          abs_x, abs_y, abs_z;

  // a tall window is clipped to the frame height
  assign end_eff   = (row_end > ROW_END_W'(MAX_ROWS)) ? ROW_END_W'(MAX_ROWS) : row_end;
  assign in_win    = (end_eff > {1'b0, row_start}) && (pixel_row >= row_start) &&
                     ({1'b0, pixel_row} < end_eff);
  assign in_col_ok = {1'b0, pixel_col} < frame_width;
  assign in_use    = in_win && in_col_ok;

  // the most negative code maps to 32768, which still fits 16 bits
  assign abs_x = coord_x[15] ? (~coord_x + 16'd1) : coord_x;
  assign abs_y = coord_y[15] ? (~coord_y + 16'd1) : coord_y;
  assign abs_z = coord_z[15] ? (~coord_z + 16'd1) : coord_z;

  logic               s1_vld;
  logic [COL_W-1:0]   s1_col;
  logic [COL_W-1:0]   s1_index;
  logic               s1_start;
  logic               s1_last;
  logic [15:0]        s1_ax, s1_ay, s1_az;
  logic [AMP_W-1:0]   s1_amp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= pixel_valid && in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col   <= pixel_col;
      s1_index <= frame_width[COL_W-1:0] - COL_W'(1) - pixel_col;
      s1_start <= pixel_row == row_start;
      s1_last  <= {1'b0, pixel_row} == (end_eff - ROW_END_W'(1));
      s1_ax    <= abs_x;
      s1_ay    <= abs_y;
      s1_az    <= abs_z;
      s1_amp   <= amplitude;
    end
  end

  // --------------------------------------------------- stage 1: squares
  logic [31:0] px, py, pz;
  assign px = s1_ax * s1_ax;
  assign py = s1_ay * s1_ay;
  assign pz = s1_az * s1_az;

  logic               s2_vld;
  logic [COL_W-1:0]   s2_col;
  logic [COL_W-1:0]   s2_index;
  logic               s2_start;
  logic               s2_last;
  logic [30:0]        s2_sqx, s2_sqy, s2_sqz;
  logic [AMP_W-1:0]   s2_amp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (advance) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_col   <= s1_col;
      s2_index <= s1_index;
      s2_start <= s1_start;
      s2_last  <= s1_last;
      s2_sqx   <= px[30:0];
      s2_sqy   <= py[30:0];
      s2_sqz   <= pz[30:0];
      s2_amp   <= s1_amp;
    end
  end

  // ------------------------------------ stage 2: sum and column store read
  logic [SQ_W-1:0] sum_sq;
  assign sum_sq = SQ_W'(s2_sqx) + SQ_W'(s2_sqy) + SQ_W'(s2_sqz);

  logic [MEM_W-1:0] col_mem [MAX_COLS];
  logic [MEM_W-1:0] rd_word;

  logic               s3_vld;
  logic [COL_W-1:0]   s3_col;
  logic [COL_W-1:0]   s3_index;
  logic               s3_start;
  logic               s3_last;
  logic [SQ_W-1:0]    s3_sq;
  logic [AMP_W-1:0]   s3_amp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (advance) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_col   <= s2_col;
      s3_index <= s2_index;
      s3_start <= s2_start;
      s3_last  <= s2_last;
      s3_sq    <= sum_sq;
      s3_amp   <= s2_amp;
    end
  end

  // ------------------------------------------- stage 3: compare and update
  // The item in stage 4 writes the store on the same edge this item reads
  // it, so a matching column takes the stage 4 value instead. Older writes
  // have already landed in the store.
  logic              s4_vld;
  logic [COL_W-1:0]  s4_col;
  logic [COL_W-1:0]  s4_index;
  logic              s4_last;
  logic [SQ_W-1:0]   s4_best;
  logic [AMP_W-1:0]  s4_amp;

  logic              fwd_hit;
  logic [SQ_W-1:0]   best_cur;
  logic [AMP_W-1:0]  amp_cur;
  logic              take;
  logic [SQ_W-1:0]   best_new;
  logic [AMP_W-1:0]  amp_new;

  assign fwd_hit  = s4_vld && (s4_col == s3_col);
  assign best_cur = fwd_hit ? s4_best : rd_word[MEM_W-1:AMP_W];
  assign amp_cur  = fwd_hit ? s4_amp  : rd_word[AMP_W-1:0];
  // first window row starts the column; after it a zero range never wins; ties keep old
  assign take     = s3_start ||
                    ((s3_sq != '0) && ((best_cur == '0) || (s3_sq < best_cur)));
  assign best_new = take ? s3_sq  : best_cur;
  assign amp_new  = take ? s3_amp : amp_cur;

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_word <= col_mem[s2_col];
      if (s3_vld) begin
        col_mem[s3_col] <= {best_new, amp_new};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (advance) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_col   <= s3_col;
      s4_index <= s3_index;
      s4_last  <= s3_last;
      s4_best  <= best_new;
      s4_amp   <= amp_new;
    end
  end

  // ------------------------------- stage 4 on: intensity and square root
  logic [AMP_W+GAIN_W-1:0] gain_prod;
  dcs_side_t               s4_side;

  assign gain_prod         = s4_amp * intensity_gain;
  assign s4_side.index     = s4_index;
  assign s4_side.found     = s4_best != '0;
  assign s4_side.intensity = s4_side.found ? gain_prod[INTENS_W+7:8] : '0;

  dcs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_vld   (s4_vld && s4_last),
    .in_value (s4_best),
    .in_side  (s4_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (advance && sq_vld) begin
      scan_valid <= 1'b1;
    end else if (!scan_stall) begin
      scan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sq_vld) begin
      scan_index     <= sq_side.index;
      scan_range     <= sq_side.found ? sq_root : {RANGE_W{1'b1}};
      scan_intensity <= sq_side.intensity;
      found          <= sq_side.found;
    end
  end

  // ------------------------------------------------------------ assertions
`include "depth_columns_to_scan_core_assert.svh"

  `DCS_ASSERT_NOW(a_empty_saturated, scan_valid && !found,
    (scan_range == {RANGE_W{1'b1}}) && (scan_intensity == '0),
    "empty column result not saturated")
  `DCS_ASSERT_NOW(a_found_nonzero, scan_valid && found, scan_range != '0,
    "found column with zero range")
  `DCS_ASSERT_NEXT(a_freeze_holds, !rst && !advance && s4_vld,
    s4_vld && $stable(s4_best) && $stable(s4_col),
    "update stage moved while pipeline frozen")

endmodule
